// ----- src/mvlr_pkg.sv -----
// Shared types and constants for the motion vector line rasteriser.
// Used by mvlr_ctrl, mvlr_dp, the top level and the checker; no dependencies.
package mvlr_pkg;

  localparam int CFG_W  = 13;  // config write data, widest register
  localparam int FW_W   = 13;
  localparam int PS_W   = 7;
  localparam int VS_W   = 5;
  localparam int MV_W   = 12;
  localparam int PIX_W  = 16;
  localparam int OFS_W  = 7;   // clamped offset, +/-63 at most
  localparam int ERR_W  = 9;
  localparam int PROD_W = MV_W + VS_W + 1;  // signed motion times unsigned scale
  localparam int QUO_W  = PROD_W - 4;

  localparam int MAX_REACH_DEF       = 63;
  localparam int GRID_INDEX_BITS_DEF = 8;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FW_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [PS_W-1:0] TILE_EDGE_RST    = 7'd16;
  localparam logic [VS_W-1:0] VECTOR_SCALE_RST = 5'd5;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_TILE_EDGE    = 2'd2,
    CFG_VECTOR_SCALE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic capture;  // latch input transaction
    logic scale;    // centres and scaled displacements
    logic setup;    // offsets, target, spans, error term
    logic emit;     // load one pixel into the output register and step
  } cmd_t;

  typedef struct packed {
    logic at_target;
    logic out_free;
  } sts_t;

endpackage

// ----- src/mvlr_ctrl.sv -----
// Sequencer for the rasteriser: idle, scale, setup, draw.
// Depends on mvlr_pkg for the command and status structs.
module mvlr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  mvlr_pkg::sts_t sts,
  output mvlr_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SETUP,
    ST_DRAW
  } state_t;

  state_t state;

  always_comb begin
    cmd         = '0;
    cmd.capture = (state == ST_IDLE) && in_valid && !rst;
    cmd.scale   = (state == ST_SCALE);
    cmd.setup   = (state == ST_SETUP);
    cmd.emit    = (state == ST_DRAW) && sts.out_free;
  end

  assign in_stall = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:  if (cmd.capture) state <= ST_SCALE;
        ST_SCALE: state <= ST_SETUP;
        ST_SETUP: state <= ST_DRAW;
        ST_DRAW:  if (cmd.emit && sts.at_target) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mvlr_dp.sv -----
// Datapath: config registers, centre and offset arithmetic, Bresenham stepper
// and the output register. Depends on mvlr_pkg; driven by mvlr_ctrl.
module mvlr_dp #(
  parameter int MAX_REACH       = mvlr_pkg::MAX_REACH_DEF,
  parameter int GRID_INDEX_BITS = mvlr_pkg::GRID_INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mvlr_pkg::CFG_W-1:0]         cfg_data,
  input  logic [GRID_INDEX_BITS-1:0]         patch_col,
  input  logic [GRID_INDEX_BITS-1:0]         patch_row,
  input  logic signed [mvlr_pkg::MV_W-1:0]   motion_x,
  input  logic signed [mvlr_pkg::MV_W-1:0]   motion_y,
  input  mvlr_pkg::cmd_t                     cmd,
  output mvlr_pkg::sts_t                     sts,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [mvlr_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [mvlr_pkg::PIX_W-1:0]  pixel_y,
  output logic                               inside_frame,
  output logic                               last_point
);

  localparam int CEN_W = GRID_INDEX_BITS + mvlr_pkg::PS_W;
  localparam int CW    = CEN_W + 2;  // centre plus signed offset
  localparam int CMP_W = (CW > mvlr_pkg::FW_W) ? CW : mvlr_pkg::FW_W;
  localparam logic signed [mvlr_pkg::QUO_W-1:0] REACH_POS = mvlr_pkg::QUO_W'(MAX_REACH);
  localparam logic signed [mvlr_pkg::QUO_W-1:0] REACH_NEG = -REACH_POS;

  logic [mvlr_pkg::FW_W-1:0] frame_width, frame_height;
  logic [mvlr_pkg::PS_W-1:0] tile_edge;
  logic [mvlr_pkg::VS_W-1:0] vector_scale;

  logic [GRID_INDEX_BITS-1:0]              col_q, row_q;
  logic signed [mvlr_pkg::MV_W-1:0]        mx_q, my_q;
  logic signed [mvlr_pkg::PROD_W-1:0]      prod_x, prod_y;
  logic signed [CW-1:0]                    cursor_x, cursor_y, target_x, target_y;
  logic [mvlr_pkg::OFS_W-1:0]              span_x, span_y;
  logic signed [mvlr_pkg::ERR_W-1:0]       error_term;
  logic                                    step_x_negative, step_y_negative;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mvlr_pkg::FRAME_WIDTH_RST;
      frame_height <= mvlr_pkg::FRAME_HEIGHT_RST;
      tile_edge    <= mvlr_pkg::TILE_EDGE_RST;
      vector_scale <= mvlr_pkg::VECTOR_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvlr_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        mvlr_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        mvlr_pkg::CFG_TILE_EDGE:    tile_edge    <= cfg_data[mvlr_pkg::PS_W-1:0];
        mvlr_pkg::CFG_VECTOR_SCALE: vector_scale <= cfg_data[mvlr_pkg::VS_W-1:0];
        default: ;
      endcase
    end
  end

  // centre = index * size + size/2
  function automatic logic [CEN_W-1:0] centre_of(input logic [GRID_INDEX_BITS-1:0] idx,
                                                 input logic [mvlr_pkg::PS_W-1:0] ps);
    logic [CEN_W-1:0] prod;
    prod = CEN_W'(idx) * CEN_W'(ps);
    return prod + CEN_W'(ps >> 1);
  endfunction

  // truncate toward zero on divide by 16, then clamp to the reach
  function automatic logic signed [mvlr_pkg::OFS_W-1:0] reach_of(
      input logic signed [mvlr_pkg::PROD_W-1:0] p);
    logic signed [mvlr_pkg::PROD_W-1:0] biased;
    logic signed [mvlr_pkg::QUO_W-1:0]  q;
    biased = p + (p[mvlr_pkg::PROD_W-1] ? mvlr_pkg::PROD_W'(15) : '0);
    q = mvlr_pkg::QUO_W'(biased >>> 4);
    if (q > REACH_POS) q = REACH_POS;
    if (q < REACH_NEG) q = REACH_NEG;
    return mvlr_pkg::OFS_W'(q);
  endfunction

  function automatic logic [mvlr_pkg::OFS_W-1:0] abs_of(
      input logic signed [mvlr_pkg::OFS_W-1:0] v);
    return v[mvlr_pkg::OFS_W-1] ? mvlr_pkg::OFS_W'(-v) : v;
  endfunction

  logic signed [mvlr_pkg::OFS_W-1:0] ox, oy;
  logic [mvlr_pkg::OFS_W-1:0]        sx_init, sy_init;
  logic signed [mvlr_pkg::ERR_W-1:0] err_init, err_next, e_sx, e_sy;
  logic                              move_x, move_y;

  assign ox      = reach_of(prod_x);
  assign oy      = reach_of(prod_y);
  assign sx_init = abs_of(ox);
  assign sy_init = abs_of(oy);
  assign err_init = (sx_init > sy_init) ? mvlr_pkg::ERR_W'(sx_init >> 1)
                                        : -mvlr_pkg::ERR_W'(sy_init >> 1);

  assign e_sx   = mvlr_pkg::ERR_W'(span_x);
  assign e_sy   = mvlr_pkg::ERR_W'(span_y);
  assign move_x = error_term > -e_sx;
  assign move_y = error_term < e_sy;
  assign err_next = error_term - (move_x ? e_sy : '0) + (move_y ? e_sx : '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= patch_col;
      row_q <= patch_row;
      mx_q  <= motion_x;
      my_q  <= motion_y;
    end
    if (cmd.scale) begin
      cursor_x <= CW'(centre_of(col_q, tile_edge));
      cursor_y <= CW'(centre_of(row_q, tile_edge));
      prod_x   <= mvlr_pkg::PROD_W'(mx_q) * $signed({1'b0, vector_scale});
      prod_y   <= mvlr_pkg::PROD_W'(my_q) * $signed({1'b0, vector_scale});
    end
    if (cmd.setup) begin
      target_x        <= cursor_x + CW'(ox);
      target_y        <= cursor_y + CW'(oy);
      span_x          <= sx_init;
      span_y          <= sy_init;
      step_x_negative <= !(ox > 0);
      step_y_negative <= !(oy > 0);
      error_term      <= err_init;
    end
    if (cmd.emit) begin
      pixel_x      <= mvlr_pkg::PIX_W'(cursor_x);
      pixel_y      <= mvlr_pkg::PIX_W'(cursor_y);
      inside_frame <= !cursor_x[CW-1] && !cursor_y[CW-1] &&
                      (CMP_W'($unsigned(cursor_x)) < CMP_W'(frame_width)) &&
                      (CMP_W'($unsigned(cursor_y)) < CMP_W'(frame_height));
      last_point   <= sts.at_target;
      error_term   <= err_next;
      if (move_x) cursor_x <= cursor_x + (step_x_negative ? {CW{1'b1}} : CW'(1));
      if (move_y) cursor_y <= cursor_y + (step_y_negative ? {CW{1'b1}} : CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.at_target = (cursor_x == target_x) && (cursor_y == target_y);
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

// ----- src/motion_vector_line_rasterizer.sv -----
// Top level of the motion vector line rasteriser: sequencer plus datapath.
// Depends on mvlr_pkg, mvlr_ctrl and mvlr_dp.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  patch_col, patch_row, motion_x, motion_y
//   out      out_valid/out_stall  pixel_x, pixel_y, inside_frame, last_point
//   cfg      cfg_we               cfg_index, cfg_data
//
// A vector passes through the accept cycle in idle, multiply, offset/target,
// then one pixel per cycle while out_stall does not hold the output register.
// The pixel stepper sets the pace.
// Synchronous active-high reset; in_stall is held high during reset.
// out_stall freezes the stepper while it holds a pixel in the output register; the last pixel
// may wait in the output register while the next transaction is accepted.
module motion_vector_line_rasterizer #(
  parameter int MAX_REACH       = mvlr_pkg::MAX_REACH_DEF,
  parameter int GRID_INDEX_BITS = mvlr_pkg::GRID_INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mvlr_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [GRID_INDEX_BITS-1:0]         patch_col,
  input  logic [GRID_INDEX_BITS-1:0]         patch_row,
  input  logic signed [mvlr_pkg::MV_W-1:0]   motion_x,
  input  logic signed [mvlr_pkg::MV_W-1:0]   motion_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mvlr_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [mvlr_pkg::PIX_W-1:0]  pixel_y,
  output logic                               inside_frame,
  output logic                               last_point
);

  mvlr_pkg::cmd_t cmd;
  mvlr_pkg::sts_t sts;

  mvlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvlr_dp #(
    .MAX_REACH       (MAX_REACH),
    .GRID_INDEX_BITS (GRID_INDEX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .patch_col    (patch_col),
    .patch_row    (patch_row),
    .motion_x     (motion_x),
    .motion_y     (motion_y),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .inside_frame (inside_frame),
    .last_point   (last_point)
  );

endmodule

// ----- src/mvlr_checker.sv -----
// Port-level checks for the rasteriser, bound to the top level.
// Depends on mvlr_pkg and motion_vector_line_rasterizer.
module mvlr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [mvlr_pkg::PIX_W-1:0]  pixel_x,
  input logic signed [mvlr_pkg::PIX_W-1:0]  pixel_y,
  input logic                               inside_frame,
  input logic                               last_point
);

  // one vector at a time: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a vector is still in progress");

  // when ready for a new vector, only the final pixel can still be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> last_point)
    else $error("ready for input with a non-final pixel pending");

  // an inside pixel always has non-negative coordinates
  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_frame |-> !pixel_x[mvlr_pkg::PIX_W-1] && !pixel_y[mvlr_pkg::PIX_W-1])
    else $error("inside pixel with negative coordinate");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
                               && $stable(last_point))
    else $error("stalled output transaction changed");

endmodule

bind motion_vector_line_rasterizer mvlr_checker u_mvlr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_x      (pixel_x),
  .pixel_y      (pixel_y),
  .inside_frame (inside_frame),
  .last_point   (last_point)
);

// ----- verif/testbench.sv -----
// Self-checking bench for motion_vector_line_rasterizer: queued vector driver,
// output monitor and an in-bench line tracer that predicts every pixel.
// Depends on mvlr_pkg and the rasteriser RTL only.
module testbench;

  typedef struct {
    logic [7:0]        col;
    logic [7:0]        row;
    logic signed [11:0] mx;
    logic signed [11:0] my;
  } vector_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               in_frame;
    logic               last;
  } pixel_t;

  localparam int REACH = 63;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [mvlr_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] patch_col = '0;
  logic [7:0] patch_row = '0;
  logic signed [mvlr_pkg::MV_W-1:0] motion_x = '0;
  logic signed [mvlr_pkg::MV_W-1:0] motion_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [mvlr_pkg::PIX_W-1:0] pixel_x;
  logic signed [mvlr_pkg::PIX_W-1:0] pixel_y;
  logic inside_frame;
  logic last_point;

  vector_t pending_vectors[$];
  pixel_t  line_pixels[$];
  int      width_reg  = 640;
  int      height_reg = 480;
  int      patch_reg  = 16;
  int      scale_reg  = 5;
  int      vectors_sent = 0;
  int      mismatches = 0;
  logic    hold_req = 1'b0;

  motion_vector_line_rasterizer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .patch_col(patch_col), .patch_row(patch_row),
    .motion_x(motion_x), .motion_y(motion_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .inside_frame(inside_frame), .last_point(last_point)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // long burst with no idling on either side
  function automatic bit quiet_stretch();
    return vectors_sent >= 200 && vectors_sent < 280;
  endfunction

  function automatic int scaled_offset(logic signed [11:0] m);
    int o;
    o = (int'(m) * scale_reg) / 16;  // truncates toward zero
    if (o > REACH) o = REACH;
    if (o < -REACH) o = -REACH;
    return o;
  endfunction

  // Bresenham walk from patch centre to endpoint, one pixel per transaction
  function automatic void trace_line(vector_t v);
    int cx, cy, tx, ty, ox, oy, dx, dy, err, e2;
    bit neg_x, neg_y;
    pixel_t p;
    cx = int'(v.col) * patch_reg + patch_reg / 2;
    cy = int'(v.row) * patch_reg + patch_reg / 2;
    ox = scaled_offset(v.mx);
    oy = scaled_offset(v.my);
    tx = cx + ox;
    ty = cy + oy;
    dx = ox < 0 ? -ox : ox;
    dy = oy < 0 ? -oy : oy;
    neg_x = !(cx < tx);
    neg_y = !(cy < ty);
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    for (int n = 0; n < 64; n++) begin
      p.x = cx[15:0];
      p.y = cy[15:0];
      p.in_frame = cx >= 0 && cx < width_reg && cy >= 0 && cy < height_reg;
      p.last = (cx == tx) && (cy == ty);
      line_pixels.push_back(p);
      if (p.last) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        cx += neg_x ? -1 : 1;
      end
      if (e2 < dy) begin
        err += dx;
        cy += neg_y ? -1 : 1;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (time %0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    vector_t v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        v.col = patch_col;
        v.row = patch_row;
        v.mx  = motion_x;
        v.my  = motion_y;
        trace_line(v);
        vectors_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_vectors.size() != 0 &&
            (quiet_stretch() || $urandom_range(0, 99) >= 11)) begin
          v = pending_vectors.pop_front();
          patch_col <= v.col;
          patch_row <= v.row;
          motion_x  <= v.mx;
          motion_y  <= v.my;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_pixels.size() == 0) begin
          report_mismatch("unexpected pixel_x", pixel_x, 0);
        end else begin
          want = line_pixels.pop_front();
          if (pixel_x !== want.x) report_mismatch("pixel_x", pixel_x, want.x);
          if (pixel_y !== want.y) report_mismatch("pixel_y", pixel_y, want.y);
          if (inside_frame !== want.in_frame)
            report_mismatch("inside_frame", inside_frame, want.in_frame);
          if (last_point !== want.last)
            report_mismatch("last_point", last_point, want.last);
        end
      end
      out_stall <= hold_req || (!quiet_stretch() && $urandom_range(0, 99) < 11);
    end
  end

  // receiver hold-off so the block fills and back-pressures its input
  initial begin
    do @(posedge clk); while (vectors_sent < 40);
    hold_req <= 1'b1;
    repeat (400) @(posedge clk);
    hold_req <= 1'b0;
  end

  initial begin
    #8000000;
    $display("[motion_vector_line_rasterizer] ERROR");
    $finish;
  end

  task automatic write_reg(mvlr_pkg::cfg_idx_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[mvlr_pkg::CFG_W-1:0];
    case (idx)
      mvlr_pkg::CFG_FRAME_WIDTH:  width_reg  = val & 'h1FFF;
      mvlr_pkg::CFG_FRAME_HEIGHT: height_reg = val & 'h1FFF;
      mvlr_pkg::CFG_TILE_EDGE:    patch_reg  = val & 'h7F;
      mvlr_pkg::CFG_VECTOR_SCALE: scale_reg  = val & 'h1F;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(int fw, int fh, int ps, int vs);
    write_reg(mvlr_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(mvlr_pkg::CFG_FRAME_HEIGHT, fh);
    write_reg(mvlr_pkg::CFG_TILE_EDGE, ps);
    write_reg(mvlr_pkg::CFG_VECTOR_SCALE, vs);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_vectors.size() != 0 || in_valid || line_pixels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_vector(int col, int row, int mx, int my);
    vector_t v;
    v.col = col[7:0];
    v.row = row[7:0];
    v.mx  = mx[11:0];
    v.my  = my[11:0];
    pending_vectors.push_back(v);
  endtask

  // mostly unclamped lengths under the current scale, some full-range values
  function automatic int pick_motion();
    int r, lim;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 65 && scale_reg != 0) begin
      lim = (64 * 16) / scale_reg;
      if (lim > 2047) lim = 2047;
      return int'($urandom_range(0, 2 * lim)) - lim;
    end
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  task automatic queue_random(int count);
    int col, row;
    repeat (count) begin
      col = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 45);
      row = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 45);
      queue_vector(col, row, pick_motion(), pick_motion());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 640x480, patch 16, scale 5
    queue_vector(0, 0, 0, 0);
    queue_vector(0, 0, -2048, -2048);
    queue_vector(255, 255, 2047, 2047);
    queue_vector(255, 0, -2048, 2047);
    queue_vector(0, 255, 2047, -2048);
    queue_vector(39, 29, 0, 0);
    queue_vector(40, 30, 0, 0);
    queue_vector(10, 10, 160, 48);
    queue_vector(10, 10, 48, 160);
    queue_vector(10, 10, -160, 48);
    queue_vector(10, 10, -48, -160);
    queue_vector(10, 10, 160, -48);
    queue_vector(10, 10, -48, 160);
    queue_vector(10, 10, -160, -48);
    queue_vector(10, 10, 48, -160);
    queue_vector(10, 10, 100, 100);
    queue_vector(10, 10, -100, 100);
    queue_vector(5, 5, -3, 4);     // fractions truncate toward zero
    queue_vector(5, 5, 4, -4);
    queue_vector(20, 20, 200, 0);
    queue_vector(20, 20, 0, -201);
    queue_vector(39, 29, 32, 32);  // crosses the frame corner
    queue_vector(128, 127, 1, -1);
    queue_random(75);
    wait_drained();

    program_regs(8191, 8191, 127, 31);
    queue_vector(255, 255, 2047, -2048);
    queue_random(50);
    wait_drained();

    // zero frame, zero patch, zero scale
    program_regs(0, 0, 0, 0);
    queue_random(20);
    wait_drained();

    program_regs(1, 4096, 1, 1);
    queue_vector(0, 0, 16, 16);
    queue_random(60);
    wait_drained();

    program_regs(4096, 1, 64, 16);
    queue_random(60);
    wait_drained();

    program_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                 $urandom_range(1, 64), $urandom_range(1, 16));
    queue_random(80);
    wait_drained();

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("[motion_vector_line_rasterizer] OK");
    end else begin
      $display("[motion_vector_line_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
